### rtl/bounded_array_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array list engine
// Each macro is a labeled concurrent assertion, or empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BALE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BALE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BALE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list engine package
// Operation and status codes shared by the engine's modules.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam logic [3:0] OP_READ   = 4'd0;
  localparam logic [3:0] OP_UPDATE = 4'd1;
  localparam logic [3:0] OP_SEARCH = 4'd2;
  localparam logic [3:0] OP_INSERT = 4'd3;
  localparam logic [3:0] OP_DELAT  = 4'd4;
  localparam logic [3:0] OP_DELNTH = 4'd5;
  localparam logic [3:0] OP_SORT   = 4'd6;
  localparam logic [3:0] OP_BSRCH  = 4'd7;
  localparam logic [3:0] OP_MIN    = 4'd8;
  localparam logic [3:0] OP_MEDIAN = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Byte address of the capacity limit register.
  localparam logic [1:0] CFG_ADDR_CAP = 2'd0;

  localparam logic [4:0] CFG_CAP_RESET = 5'd16;

  // Compare result of the shared unit.
  typedef struct packed {
    logic eq;
    logic gt;   // a > b, signed
  } bale_cmp_t;

endpackage

### rtl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded array list engine
// Top level: stream ports, configuration register and result register.
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY signed 32-bit values and runs one list
// operation per input word. Reads, updates, rejected requests and a sort of
// at most one item go straight to the done state. A search walks all n items
// held; an insert at position p shifts the items from the end down to p, and
// a delete at p shifts the items above p down by one. Delete of the nth
// occurrence walks the items until the hit and then deletes there. Sort
// runs a bubble sort through the single shared comparator, one
// compare-exchange per cycle; minimum and median add a median step after the
// sort. Binary search makes one probe per cycle and, when the value is
// missing, a last step that finds the range empty. The input is not
// ready while an operation runs or while a result word waits in the output
// register.
module bounded_array_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] op, [8:4] index, [40:9] value, [45:41] occurrence, zero filled
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status, [5:2] found_index, [10:6] match_count, [42:11] data,
  // [47:43] item_count
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
`include "bounded_array_list_engine_macros.svh"

  logic [4:0]  cap_r;
  logic        ov_r;
  logic [47:0] od_r;
  logic        busy, done, start;
  logic [1:0]  r_st;
  logic [3:0]  r_fi;
  logic [4:0]  r_mc, r_cnt;
  logic [31:0] r_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == bale_pkg::CFG_ADDR_CAP) ? {27'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= bale_pkg::CFG_CAP_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == bale_pkg::CFG_ADDR_CAP)
      cap_r <= cfg_pwdata[4:0];
  end

  // A new word is taken only with the sequencer idle and the result slot empty.
  assign in_tready = !busy && !ov_r;
  assign start     = in_tvalid && in_tready;

  bale_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk(clk), .rst_n(rst_n), .cap_limit(cap_r), .start(start),
    .op(in_tdata[3:0]), .index(in_tdata[8:4]), .value(in_tdata[40:9]),
    .occurrence(in_tdata[45:41]), .busy(busy), .done(done),
    .res_status(r_st), .res_found(r_fi), .res_mcount(r_mc),
    .res_data(r_data), .res_count(r_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) begin
      ov_r <= 1'b1;
      od_r <= {r_cnt, r_data, r_mc, r_fi, r_st};
    end else if (out_tready) ov_r <= 1'b0;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  `BALE_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !in_tready)
  `BALE_ASSERT_NEXT(a_done_sets_valid, clk, rst_n, done, out_tvalid)
  `BALE_ASSERT_IMPL(a_count_bound, clk, rst_n, out_tvalid, out_tdata[47:43] <= 5'd16)
endmodule

### rtl/bale_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare and add unit
// Signed compare of two words and their halved sum, truncated toward zero.
// ----------------------------------------------------------------------------
module bale_cmp (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output bale_pkg::bale_cmp_t cmp,
  output logic signed [31:0] half_sum
);
  logic signed [32:0] sum;
  logic signed [32:0] adj;

  assign cmp.eq   = (a == b);
  assign cmp.gt   = (a > b);
  assign sum      = 33'(a) + 33'(b);
  // Add one before the shift for negative sums so the result truncates toward zero.
  assign adj      = sum + 33'(sum[32]);
  assign half_sum = adj[32:1];
endmodule

### rtl/bale_seq.sv
// ----------------------------------------------------------------------------
// Operation sequencer and store
// Steps through the store one entry or probe per cycle; compares use the shared compare unit.
// ----------------------------------------------------------------------------
module bale_seq #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  cap_limit,
  input  logic        start,
  input  logic [3:0]  op,
  input  logic [4:0]  index,
  input  logic [31:0] value,
  input  logic [4:0]  occurrence,
  output logic        busy,
  output logic        done,
  output logic [1:0]  res_status,
  output logic [3:0]  res_found,
  output logic [4:0]  res_mcount,
  output logic [31:0] res_data,
  output logic [4:0]  res_count
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_INSERT, S_REMOVE, S_DELNTH, S_SORT, S_BSRCH, S_MEDIAN, S_DONE
  } state_t;

  state_t state_r;
  logic signed [31:0] store_r [CAPACITY];
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r, j_r, lim_r;
  logic [CW:0]   lo_r, hi_r;
  logic [CW-1:0] mid;
  logic [3:0]  op_r;
  logic [CW-1:0] idx_r;
  logic [31:0] val_r;
  logic [4:0]  occ_r, seen_r;
  logic [1:0]  st_r;
  logic [3:0]  fnd_r;
  logic [4:0]  mc_r;
  logic [31:0] data_r;

  logic signed [31:0] ua, ub, hsum;
  bale_pkg::bale_cmp_t cmp;
  logic [CW-1:0] cap_c;

  bale_cmp u_cmp (.a(ua), .b(ub), .cmp(cmp), .half_sum(hsum));

  assign mid = CW'((lo_r + hi_r) >> 1);
  always_comb begin
    cap_c = (cap_limit == 5'd0) ? CW'(1) :
            ({27'd0, cap_limit} > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_limit);
    ua = 32'sd0;
    ub = 32'sd0;
    case (state_r)
      S_SEARCH, S_DELNTH: begin
        ua = store_r[i_r[IW-1:0]];
        ub = val_r;
      end
      S_SORT: begin
        ua = store_r[j_r[IW-1:0]];
        ub = store_r[IW'(j_r + CW'(1))];
      end
      S_BSRCH: begin
        ua = store_r[mid[IW-1:0]];
        ub = val_r;
      end
      S_MEDIAN: begin
        ua = store_r[IW'((count_r >> 1) - CW'(1))];
        ub = store_r[IW'(count_r >> 1)];
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign res_status = st_r;
  assign res_found  = fnd_r;
  assign res_mcount = mc_r;
  assign res_data   = data_r;
  assign res_count  = 5'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      for (int k = 0; k < CAPACITY; k++) store_r[k] <= 32'sd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= op; val_r <= value; occ_r <= occurrence;
            idx_r <= CW'(index);
            st_r <= bale_pkg::ST_OK; fnd_r <= '0; mc_r <= '0; data_r <= '0;
            i_r <= '0; j_r <= '0; seen_r <= '0;
            lim_r <= count_r; lo_r <= '0; hi_r <= (CW+1)'(count_r) - 1'b1;
            state_r <= S_DONE;
            if (op > bale_pkg::OP_MEDIAN) begin
              st_r <= bale_pkg::ST_BAD;
            end else if (count_r == '0 && op != bale_pkg::OP_INSERT &&
                         op != bale_pkg::OP_SORT) begin
              st_r <= bale_pkg::ST_EMPTY;
            end else begin
              case (op)
                bale_pkg::OP_READ: begin
                  if ({27'd0, index} < 32'(count_r)) data_r <= store_r[IW'(index)];
                  else st_r <= bale_pkg::ST_BAD;
                end
                bale_pkg::OP_UPDATE: begin
                  if ({27'd0, index} < 32'(count_r)) store_r[IW'(index)] <= value;
                  else st_r <= bale_pkg::ST_BAD;
                end
                bale_pkg::OP_SEARCH: state_r <= S_SEARCH;
                bale_pkg::OP_INSERT: begin
                  if ({27'd0, index} > 32'(count_r) || count_r >= cap_c)
                    st_r <= bale_pkg::ST_BAD;
                  else begin
                    i_r <= count_r;
                    state_r <= S_INSERT;
                  end
                end
                bale_pkg::OP_DELAT: begin
                  if ({27'd0, index} < 32'(count_r)) begin
                    i_r <= CW'(index);
                    state_r <= S_REMOVE;
                  end else st_r <= bale_pkg::ST_BAD;
                end
                bale_pkg::OP_DELNTH: state_r <= S_DELNTH;
                bale_pkg::OP_BSRCH: state_r <= S_BSRCH;
                default: begin
                  // Sort, minimum and median start with a bubble sort when more than one item is held.
                  state_r <= (count_r > CW'(1)) ? S_SORT :
                             (op == bale_pkg::OP_SORT) ? S_DONE : S_MEDIAN;
                end
              endcase
            end
          end
        end
        S_SEARCH: begin
          if (cmp.eq) begin
            if (mc_r == '0) fnd_r <= 4'(i_r);
            mc_r <= mc_r + 5'd1;
          end
          if (i_r + CW'(1) == count_r) begin
            if (mc_r == '0 && !cmp.eq) st_r <= bale_pkg::ST_NONE;
            state_r <= S_DONE;
          end
          i_r <= i_r + CW'(1);
        end
        S_INSERT: begin
          if (i_r == idx_r) begin
            store_r[IW'(i_r)] <= val_r;
            count_r <= count_r + CW'(1);
            state_r <= S_DONE;
          end else begin
            store_r[IW'(i_r)] <= store_r[IW'(i_r - CW'(1))];
            i_r <= i_r - CW'(1);
          end
        end
        S_REMOVE: begin
          if (i_r + CW'(1) >= count_r) begin
            store_r[IW'(i_r)] <= 32'sd0;
            count_r <= count_r - CW'(1);
            state_r <= S_DONE;
          end else begin
            store_r[IW'(i_r)] <= store_r[IW'(i_r + CW'(1))];
            i_r <= i_r + CW'(1);
          end
        end
        S_DELNTH: begin
          if (cmp.eq && seen_r + 5'd1 == occ_r) begin
            state_r <= S_REMOVE;
          end else begin
            if (cmp.eq) seen_r <= seen_r + 5'd1;
            if (i_r + CW'(1) == count_r) begin
              st_r <= bale_pkg::ST_NONE;
              state_r <= S_DONE;
            end else i_r <= i_r + CW'(1);
          end
        end
        S_SORT: begin
          // One compare-exchange per cycle; lim_r shrinks each pass.
          if (cmp.gt) begin
            store_r[IW'(j_r)] <= ub;
            store_r[IW'(j_r + CW'(1))] <= ua;
          end
          if (j_r + CW'(2) >= lim_r) begin
            j_r <= '0;
            lim_r <= lim_r - CW'(1);
            if (lim_r <= CW'(2))
              state_r <= (op_r == bale_pkg::OP_SORT) ? S_DONE : S_MEDIAN;
          end else j_r <= j_r + CW'(1);
        end
        S_BSRCH: begin
          if ($signed(lo_r) > $signed(hi_r)) begin
            st_r <= bale_pkg::ST_NONE;
            state_r <= S_DONE;
          end else if (cmp.eq) begin
            fnd_r <= 4'(mid);
            state_r <= S_DONE;
          end else if (cmp.gt) hi_r <= (CW+1)'(mid) - 1'b1;
          else lo_r <= (CW+1)'(mid) + 1'b1;
        end
        S_MEDIAN: begin
          if (op_r == bale_pkg::OP_MIN) data_r <= store_r[0];
          else if (count_r[0]) data_r <= ub;
          else data_r <= hsum;
          state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
